### src/pidl_pkg.sv
`default_nettype none

package pidl_pkg;

  // widest position or fill value over the supported depth range
  localparam int unsigned POS_W = 7;

  localparam int unsigned CMD_W = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POSITION_W = 8;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] fill;
  } shift_ctrl_t;

endpackage

`default_nettype wire

### src/positional_insert_delete_list.sv
// channel  | signals                        | handshake
// command  | cmd, value, position           | taken when start is high and busy is low
// result   | status, count, removed         | valid for one cycle while done is high
//
// one command per cycle; its result appears with done on the following cycle
// every cell shifts left, right, loads or holds in parallel within that cycle
// busy stays low, so a command may be issued every cycle
// rst is synchronous; it empties the list and clears done
// the receiver cannot stall: each result is gone after its single done cycle
`default_nettype none

module positional_insert_delete_list #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [pidl_pkg::CMD_W-1:0]          cmd,
  input  wire logic [pidl_pkg::VALUE_W-1:0]        value,
  input  wire logic [pidl_pkg::POSITION_W-1:0]     position,
  output logic                                     done,
  output logic      [pidl_pkg::STATUS_W-1:0]       status,
  output logic      [pidl_pkg::COUNT_W-1:0]        count,
  output logic      [pidl_pkg::VALUE_W-1:0]        removed
);

  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [FW-1:0] FULL_FILL = FW'(DEPTH);

  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;
  logic [pidl_pkg::POSITION_W:0] pos_ext;
  logic [pidl_pkg::POSITION_W:0] fill_ext;
  logic [FW-1:0] idx;
  logic ins_ok;
  logic del_ok;
  logic [pidl_pkg::STATUS_W-1:0] status_next;
  logic accept;
  logic [DATA_WIDTH-1:0] ins_data;
  logic [DATA_WIDTH-1:0] row [DEPTH];
  logic [DATA_WIDTH-1:0] sel_data;
  pidl_pkg::shift_ctrl_t ctrl;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign pos_ext  = (pidl_pkg::POSITION_W + 1)'(position);
  assign fill_ext = (pidl_pkg::POSITION_W + 1)'(fill);
  assign ins_data = DATA_WIDTH'(value);

  always_comb begin
    status_next = pidl_pkg::ST_OK;
    ins_ok      = 1'b0;
    del_ok      = 1'b0;
    idx         = '0;
    case (cmd)
      pidl_pkg::CMD_INS_FRONT, pidl_pkg::CMD_INS_BACK: begin
        if (fill == FULL_FILL) begin
          status_next = pidl_pkg::ST_FULL;
        end else begin
          ins_ok = 1'b1;
          idx    = (cmd == pidl_pkg::CMD_INS_FRONT) ? '0 : fill;
        end
      end
      pidl_pkg::CMD_DEL_FRONT, pidl_pkg::CMD_DEL_BACK: begin
        if (fill == '0) begin
          status_next = pidl_pkg::ST_EMPTY;
        end else begin
          del_ok = 1'b1;
          idx    = (cmd == pidl_pkg::CMD_DEL_FRONT) ? '0 : fill - FW'(1);
        end
      end
      pidl_pkg::CMD_INS_AT: begin
        if (pos_ext == '0 || pos_ext > fill_ext + 9'd1) begin
          status_next = pidl_pkg::ST_INVALID;
        end else if (fill == FULL_FILL) begin
          status_next = pidl_pkg::ST_FULL;
        end else begin
          ins_ok = 1'b1;
          idx    = FW'(pos_ext - 9'd1);
        end
      end
      pidl_pkg::CMD_DEL_AT: begin
        if (pos_ext == '0 || pos_ext > fill_ext) begin
          status_next = pidl_pkg::ST_INVALID;
        end else begin
          del_ok = 1'b1;
          idx    = FW'(pos_ext - 9'd1);
        end
      end
      default: begin
        status_next = pidl_pkg::ST_INVALID;
      end
    endcase
  end

  always_comb begin
    ctrl.ins  = accept && ins_ok;
    ctrl.del  = accept && del_ok;
    ctrl.idx  = pidl_pkg::POS_W'(idx);
    ctrl.fill = pidl_pkg::POS_W'(fill);
  end

  always_comb begin
    fill_next = fill;
    if (ctrl.ins) begin
      fill_next = fill + FW'(1);
    end else if (ctrl.del) begin
      fill_next = fill - FW'(1);
    end
  end

  assign sel_data = row[idx[IW-1:0]];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = ins_data;
    end else begin : g_inner_l
      assign left_data = row[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner_r
      assign right_data = row[i+1];
    end
    pidl_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .INDEX     (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .ins_data  (ins_data),
      .from_left (left_data),
      .from_right(right_data),
      .data      (row[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      done <= 1'b0;
    end else begin
      fill <= fill_next;
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status  <= status_next;
      count   <= pidl_pkg::COUNT_W'(fill_next);
      removed <= del_ok ? pidl_pkg::VALUE_W'(sel_data) : '0;
    end
  end

endmodule

`default_nettype wire

### src/pidl_cell.sv
`default_nettype none

module pidl_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned INDEX      = 0
) (
  input  wire logic                  clk,
  input  wire pidl_pkg::shift_ctrl_t ctrl,
  input  wire logic [DATA_WIDTH-1:0] ins_data,
  input  wire logic [DATA_WIDTH-1:0] from_left,
  input  wire logic [DATA_WIDTH-1:0] from_right,
  output logic      [DATA_WIDTH-1:0] data
);

  localparam logic [pidl_pkg::POS_W-1:0] POS      = pidl_pkg::POS_W'(INDEX);
  localparam logic [pidl_pkg::POS_W-1:0] POS_NEXT = pidl_pkg::POS_W'(INDEX + 1);

  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    if (ctrl.ins) begin
      if (POS == ctrl.idx) begin
        data_next = ins_data;
      end else if (POS > ctrl.idx && POS <= ctrl.fill) begin
        data_next = from_left;
      end
    end else if (ctrl.del) begin
      if (POS >= ctrl.idx && POS_NEXT < ctrl.fill) begin
        data_next = from_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

### bench/tb_positional_insert_delete_list.sv
module tb_positional_insert_delete_list;
  timeunit 1ns;
  timeprecision 1ps;

  import pidl_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned ITEMS = 1700;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  removed;
  } list_outcome_t;

  typedef struct packed {
    logic [CMD_W-1:0]      op;
    logic [VALUE_W-1:0]    val;
    logic [POSITION_W-1:0] pos;
    logic [4:0]            reps;
    logic                  pinned;
    list_outcome_t         want;
  } cmd_row_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [CMD_W-1:0]      cmd;
  logic [VALUE_W-1:0]    value;
  logic [POSITION_W-1:0] position;
  logic                  done;
  logic [STATUS_W-1:0]   status;
  logic [COUNT_W-1:0]    count;
  logic [VALUE_W-1:0]    removed;

  logic [VALUE_W-1:0] list_q[$];
  list_outcome_t      pending_results[$];
  cmd_row_t           cmd_rows[$];
  logic               pin_use;
  list_outcome_t      pin_outcome;
  int                 idle_pct;
  int                 errors;
  int                 stall_cycles;

  positional_insert_delete_list #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(VALUE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .value(value),
    .position(position),
    .done(done),
    .status(status),
    .count(count),
    .removed(removed)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic list_outcome_t apply_list_cmd(logic [CMD_W-1:0] op,
                                                   logic [VALUE_W-1:0] val,
                                                   logic [POSITION_W-1:0] pos);
    list_outcome_t res;
    int n;
    int idx;
    n = list_q.size();
    idx = -1;
    res.status = ST_OK;
    res.removed = '0;
    case (op)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (n >= DEPTH) res.status = ST_FULL;
        else list_q.insert((op == CMD_INS_FRONT) ? 0 : n, val);
      end
      CMD_DEL_FRONT, CMD_DEL_BACK: begin
        if (n == 0) res.status = ST_EMPTY;
        else idx = (op == CMD_DEL_FRONT) ? 0 : n - 1;
      end
      CMD_INS_AT: begin
        if (pos < 1 || pos > n + 1) res.status = ST_INVALID;
        else if (n >= DEPTH) res.status = ST_FULL;
        else list_q.insert(int'(pos) - 1, val);
      end
      CMD_DEL_AT: begin
        if (pos < 1 || pos > n) res.status = ST_INVALID;
        else idx = int'(pos) - 1;
      end
      default: res.status = ST_INVALID;
    endcase
    if (idx >= 0) begin
      res.removed = list_q[idx];
      list_q.delete(idx);
    end
    res.count = COUNT_W'(list_q.size());
    return res;
  endfunction

  // checks results and records accepted transactions
  always @(posedge clk) begin
    list_outcome_t want;
    list_outcome_t got;
    logic moved;
    moved = 1'b0;
    if (!rst) begin
      if (done) begin
        moved = 1'b1;
        got = '{status, count, removed};
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d count %0d removed %h",
                 got.status, got.count, got.removed);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.count !== want.count) begin
            $error("count mismatch: expected %0d, got %0d", want.count, got.count);
            errors++;
          end
          if (got.removed !== want.removed) begin
            $error("removed mismatch: expected %h, got %h", want.removed, got.removed);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        want = apply_list_cmd(cmd, value, position);
        pending_results.push_back(pin_use ? pin_outcome : want);
      end
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic issue(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] val,
                       input logic [POSITION_W-1:0] pos, input logic pinned,
                       input list_outcome_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    value <= val;
    position <= pos;
    pin_use = pinned;
    pin_outcome = want;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic issue_random(input int mode);
    logic [CMD_W-1:0] op;
    logic [POSITION_W-1:0] pos;
    int r;
    int ins_pct;
    int upper;
    int pick;
    r = $urandom_range(99);
    ins_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
    pos = POSITION_W'($urandom_range(255));
    if (r < 3) begin
      op = $urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
    end else begin
      pick = $urandom_range(2);
      if ($urandom_range(99) < ins_pct) begin
        op = (pick == 0) ? CMD_INS_FRONT : (pick == 1) ? CMD_INS_BACK : CMD_INS_AT;
        upper = list_q.size() + 1;
      end else begin
        op = (pick == 0) ? CMD_DEL_FRONT : (pick == 1) ? CMD_DEL_BACK : CMD_DEL_AT;
        upper = list_q.size();
      end
      r = $urandom_range(9);
      if (r == 1) begin
        pick = $urandom_range(2);
        pos = (pick == 0) ? '0 : (pick == 1) ? POSITION_W'(upper) : POSITION_W'(upper + 1);
      end else if (r > 1 && upper > 0) begin
        pos = POSITION_W'($urandom_range(upper, 1));
      end
    end
    issue(op, $urandom, pos, 1'b0, '0);
  endtask

  initial begin
    int mode;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    value = '0;
    position = '0;
    pin_use = 1'b0;
    pin_outcome = '0;
    idle_pct = 13;
    errors = 0;
    stall_cycles = 0;

    // empty list, bad positions, single element, fill to full, partial drain
    cmd_rows.push_back('{CMD_DEL_FRONT, 32'h0, 8'd0, 5'd1, 1'b1, '{ST_EMPTY, 5'd0, 32'h0}});
    cmd_rows.push_back('{CMD_DEL_BACK, 32'h0, 8'd0, 5'd1, 1'b1, '{ST_EMPTY, 5'd0, 32'h0}});
    cmd_rows.push_back('{CMD_DEL_AT, 32'h0, 8'd0, 5'd1, 1'b1, '{ST_INVALID, 5'd0, 32'h0}});
    cmd_rows.push_back('{CMD_INS_AT, 32'h1, 8'd0, 5'd1, 1'b1, '{ST_INVALID, 5'd0, 32'h0}});
    cmd_rows.push_back('{CMD_UNUSED_HI, 32'h2, 8'd1, 5'd1, 1'b1, '{ST_INVALID, 5'd0, 32'h0}});
    cmd_rows.push_back('{CMD_INS_FRONT, 32'hFFFF_FFFF, 8'd0, 5'd1, 1'b1,
                         '{ST_OK, 5'd1, 32'h0}});
    cmd_rows.push_back('{CMD_DEL_AT, 32'h0, 8'd1, 5'd1, 1'b1,
                         '{ST_OK, 5'd0, 32'hFFFF_FFFF}});
    cmd_rows.push_back('{CMD_INS_AT, 32'h8000_0001, 8'd1, 5'd16, 1'b0, '0});
    cmd_rows.push_back('{CMD_INS_BACK, 32'h3, 8'd0, 5'd1, 1'b1, '{ST_FULL, 5'd16, 32'h0}});
    cmd_rows.push_back('{CMD_INS_AT, 32'h4, 8'd17, 5'd1, 1'b1, '{ST_FULL, 5'd16, 32'h0}});
    cmd_rows.push_back('{CMD_INS_AT, 32'h5, 8'd18, 5'd1, 1'b1, '{ST_INVALID, 5'd16, 32'h0}});
    cmd_rows.push_back('{CMD_INS_AT, 32'h0, 8'd255, 5'd1, 1'b1, '{ST_INVALID, 5'd16, 32'h0}});
    cmd_rows.push_back('{CMD_DEL_AT, 32'h0, 8'd16, 5'd1, 1'b0, '0});
    cmd_rows.push_back('{CMD_DEL_AT, 32'h0, 8'd255, 5'd1, 1'b1, '{ST_INVALID, 5'd15, 32'h0}});
    cmd_rows.push_back('{CMD_DEL_BACK, 32'h0, 8'd0, 5'd1, 1'b0, '0});
    cmd_rows.push_back('{CMD_DEL_FRONT, 32'h0, 8'd0, 5'd1, 1'b0, '0});
    cmd_rows.push_back('{CMD_UNUSED_LO, 32'h0, 8'd0, 5'd1, 1'b1, '{ST_INVALID, 5'd13, 32'h0}});
    cmd_rows.push_back('{CMD_DEL_AT, 32'h0, 8'd1, 5'd1, 1'b0, '0});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (cmd_rows[i]) begin
      for (int k = 0; k < cmd_rows[i].reps; k++) begin
        issue(cmd_rows[i].op, cmd_rows[i].val + k, cmd_rows[i].pos,
              cmd_rows[i].pinned, cmd_rows[i].want);
      end
    end

    // grow, shrink and mixed stretches of random transactions
    mode = 2;
    for (int n = 0; n < ITEMS; n++) begin
      if (n == ITEMS / 3) idle_pct = 59;
      if (n == 2 * ITEMS / 3) idle_pct = 0;
      if (n % 40 == 0) mode = $urandom_range(2);
      issue_random(mode);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/pidl_pkg.sv
src/pidl_cell.sv
src/positional_insert_delete_list.sv
bench/tb_positional_insert_delete_list.sv
